/* rtl/longest_run_with_holes_finder_top_defines.svh */
// ----------------------------------------------------------------------------
// longest run with holes finder assertion macros
// shared property forms for the checker of the finder block
// ----------------------------------------------------------------------------
`ifndef LONGEST_RUN_WITH_HOLES_FINDER_TOP_DEFINES_SVH
`define LONGEST_RUN_WITH_HOLES_FINDER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define LRHF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define LRHF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/lrhf_pkg.sv */
// ----------------------------------------------------------------------------
// lrhf_pkg
// types and constants of the longest run with holes finder
// ----------------------------------------------------------------------------
`default_nettype none

package lrhf_pkg;

	localparam int LEN_W = 10;
	localparam int TIE_W = 11;
	localparam logic [TIE_W-1:0] TIE_MAX = '1;

	// register map, indexed by paddr[2]
	localparam logic REG_HOLE_SPAN  = 1'b0;
	localparam logic REG_HOLE_VALUE = 1'b1;

	localparam logic [LEN_W-1:0] HOLE_SPAN_RESET  = 10'd20;
	localparam logic             HOLE_VALUE_RESET = 1'b0;

	typedef struct packed {
		logic bit_value;
		logic last_bit;
	} in_item_t;

	typedef struct packed {
		logic             found;
		logic [LEN_W-1:0] best_length;
		logic [LEN_W-1:0] best_start;
		logic [LEN_W-1:0] best_end;
		logic [TIE_W-1:0] tie_count;
		logic             overflow;
	} out_item_t;

endpackage

`default_nettype wire

/* rtl/longest_run_with_holes_finder_top.sv */
// ----------------------------------------------------------------------------
// longest run with holes finder
// streams a bit vector one bit per request and reports its longest segment
// ----------------------------------------------------------------------------
// A vector arrives one bit per input request, index 0 first, and its final
// bit carries last_bit. Bits equal to hole_value are holes, all others are
// marks; marks no more than max_hole_span indices apart belong to one
// segment, and a segment's length is its last index minus its first. On the
// final bit the block emits one result request with the earliest longest
// segment, the number of segments sharing that length (saturating at 2047)
// and an overflow flag when the vector ran past MAX_LEN bits; bits beyond
// MAX_LEN are dropped but their last_bit still ends the vector. The block
// takes one bit per cycle: each bit is latched in an input register and is
// folded from there into the running state by one subtract and compare
// against the open segment plus up to two compares against the current
// best; a final bit's result is registered in the output register. The only
// stall is a final bit arriving while the previous result still sits unread
// in the output register. Registers must be written through the APB-style
// port only while no vector is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module longest_run_with_holes_finder_top
	import lrhf_pkg::*;
#(
	parameter int MAX_LEN = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// bit stream
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_item_t    in_data,
	// result
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_item_t        out_data,
	// register port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	// index width covers 0 .. MAX_LEN-1, position also holds MAX_LEN itself
	localparam int IW = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;
	localparam int PW = $clog2(MAX_LEN + 1);
	localparam int CW = IW + LEN_W;
	localparam logic [PW-1:0] POS_LIMIT = PW'(MAX_LEN);

	typedef struct packed {
		logic             have;
		logic [IW-1:0]    len;
		logic [IW-1:0]    first;
		logic [IW-1:0]    last;
		logic [TIE_W-1:0] cnt;
	} best_t;

	typedef struct packed {
		logic          open;
		logic [IW-1:0] first;
		logic [IW-1:0] latest;
	} seg_t;

	// fold a closed segment into the best record
	function automatic best_t merge_seg(best_t b, seg_t s);
		best_t         r;
		logic [IW-1:0] len;
		r   = b;
		len = s.latest - s.first;
		if (s.open) begin
			if (!b.have || len > b.len) begin
				r.have  = 1'b1;
				r.len   = len;
				r.first = s.first;
				r.last  = s.latest;
				r.cnt   = TIE_W'(1);
			end else if (len == b.len && b.cnt != TIE_MAX) begin
				r.cnt = b.cnt + TIE_W'(1);
			end
		end
		return r;
	endfunction

	// zero-extend or truncate an index to the 10-bit result fields
	function automatic logic [LEN_W-1:0] to_field(logic [IW-1:0] v);
		logic [CW-1:0] w;
		w = CW'(v);
		return w[LEN_W-1:0];
	endfunction

	// ---------------- register port ----------------
	logic [LEN_W-1:0] hole_span_q;
	logic             hole_value_q;
	logic             reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hole_span_q  <= HOLE_SPAN_RESET;
			hole_value_q <= HOLE_VALUE_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (reg_sel)
				REG_HOLE_SPAN:  hole_span_q  <= pwdata[LEN_W-1:0];
				REG_HOLE_VALUE: hole_value_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_HOLE_SPAN:  prdata = 32'(hole_span_q);
			REG_HOLE_VALUE: prdata = 32'(hole_value_q);
			default:        prdata = '0;
		endcase
	end

	// ---------------- input register ----------------
	logic     valid_s1;
	in_item_t item_s1;
	logic     advance;

	// a final bit waits only while the previous result is still unread
	assign advance  = valid_s1 && !(item_s1.last_bit && out_valid && !out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// ---------------- running state ----------------
	logic [PW-1:0] pos_q;
	seg_t          seg_q;
	best_t         best_q;
	logic          ovf_q;

	logic          in_range;
	logic          is_mark;
	logic [IW-1:0] pos_idx;
	logic [IW-1:0] gap;
	logic          extend;
	seg_t          seg_nxt;
	best_t         best_mid;
	best_t         best_fin;
	out_item_t     result;

	assign in_range = pos_q < POS_LIMIT;
	assign is_mark  = item_s1.bit_value != hole_value_q;
	assign pos_idx  = pos_q[IW-1:0];
	assign gap      = pos_idx - seg_q.latest;
	// compare in a width that holds both the gap and the span
	assign extend   = seg_q.open && (CW'(gap) <= CW'(hole_span_q));

	always_comb begin
		seg_nxt  = seg_q;
		best_mid = best_q;
		if (in_range && is_mark) begin
			if (extend) begin
				seg_nxt.latest = pos_idx;
			end else begin
				// the open segment ends before this mark starts a new one
				best_mid      = merge_seg(best_q, seg_q);
				seg_nxt.open  = 1'b1;
				seg_nxt.first = pos_idx;
				seg_nxt.latest = pos_idx;
			end
		end
		// end of vector closes whatever is still open
		best_fin = merge_seg(best_mid, seg_nxt);
	end

	always_comb begin
		result.found       = best_fin.len != '0;
		result.best_length = to_field(best_fin.len);
		result.best_start  = to_field(best_fin.first);
		result.best_end    = to_field(best_fin.last);
		result.tie_count   = best_fin.cnt;
		result.overflow    = ovf_q || !in_range;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			seg_q  <= '0;
			best_q <= '0;
			ovf_q  <= 1'b0;
		end else if (advance) begin
			if (item_s1.last_bit) begin
				// vector done, start clean for the next one
				pos_q  <= '0;
				seg_q  <= '0;
				best_q <= '0;
				ovf_q  <= 1'b0;
			end else begin
				pos_q  <= in_range ? pos_q + PW'(1) : pos_q;
				seg_q  <= seg_nxt;
				best_q <= best_mid;
				ovf_q  <= ovf_q || !in_range;
			end
		end
	end

	// ---------------- result register ----------------
	logic      out_valid_q;
	out_item_t out_data_q;
	logic      load_out;

	assign load_out = advance && item_s1.last_bit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

/* rtl/lrhf_checker.sv */
// ----------------------------------------------------------------------------
// lrhf_checker
// port-level checks on the longest run with holes finder
// ----------------------------------------------------------------------------
`default_nettype none

`include "longest_run_with_holes_finder_top_defines.svh"

module lrhf_checker
	import lrhf_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire out_item_t   out_data
);

	logic stalled;
	logic found_ok;
	logic empty_fields;
	logic range_ok;

	assign stalled      = out_valid && !out_ready;
	assign found_ok     = out_data.found == (out_data.best_length != '0);
	assign empty_fields = !out_data.found && out_data.best_length == '0 &&
		out_data.best_start == '0 && out_data.best_end == '0;
	assign range_ok     = LEN_W'(out_data.best_end - out_data.best_start) ==
		out_data.best_length;

	// a stalled result holds
	`LRHF_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(out_data), "stalled result changed")

	// found tracks a nonzero length
	`LRHF_ASSERT_NOW(a_found, out_valid, found_ok, "found disagrees with best_length")

	// no segment means an all-zero result
	`LRHF_ASSERT_NOW(a_empty, out_valid && out_data.tie_count == '0, empty_fields, "empty result")

	// length equals end minus start
	`LRHF_ASSERT_NOW(a_span, out_valid, range_ok, "length does not match range")

endmodule

bind longest_run_with_holes_finder_top lrhf_checker u_lrhf_checker (.*);

`default_nettype wire
